// File: rtl/bcpg_pkg.sv
package bcpg_pkg;

    // Field widths of the item and result payloads.
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned TONE_W    = 3;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned PITCH_W   = 10;
    localparam int unsigned TICKS_W   = 16;
    localparam int unsigned ELAPSED_W = 17;

    // Configuration port geometry.
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PRESET = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_ON_TICKS    = 2'd0;
    localparam logic [1:0] REG_OFF_TICKS   = 2'd1;
    localparam logic [1:0] REG_PAUSE_TICKS = 2'd2;
    localparam logic [1:0] REG_UNUSED      = 2'd3;

    // Register reset values.
    localparam logic [TICKS_W-1:0] ON_TICKS_RESET    = 16'd100;
    localparam logic [TICKS_W-1:0] OFF_TICKS_RESET   = 16'd100;
    localparam logic [TICKS_W-1:0] PAUSE_TICKS_RESET = 16'd1000;

    // Tone index that keeps the current pitch pair.
    localparam logic [TONE_W-1:0] TONE_KEEP = 3'd7;

    typedef struct packed {
        logic [TICKS_W-1:0] on_ticks;
        logic [TICKS_W-1:0] off_ticks;
        logic [TICKS_W-1:0] pause_ticks;
    } cfg_t;

    typedef struct packed {
        logic [PITCH_W-1:0] period;
        logic [PITCH_W-1:0] compare;
    } pitch_t;

    // Period and compare pair of each note, Do through Si.
    function automatic pitch_t tone_pitch(input logic [TONE_W-1:0] tone);
        pitch_t p;
        unique case (tone)
            3'd0: p = '{period: 10'd916, compare: 10'd458};
            3'd1: p = '{period: 10'd816, compare: 10'd408};
            3'd2: p = '{period: 10'd727, compare: 10'd363};
            3'd3: p = '{period: 10'd698, compare: 10'd349};
            3'd4: p = '{period: 10'd611, compare: 10'd458};
            3'd5: p = '{period: 10'd544, compare: 10'd272};
            3'd6: p = '{period: 10'd485, compare: 10'd242};
            default: p = '{period: '0, compare: '0};
        endcase
        return p;
    endfunction

endpackage

// File: rtl/bcpg_in_if.sv
interface bcpg_in_if;
    import bcpg_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [TONE_W-1:0]  tone;
    logic [COUNT_W-1:0] beep_number;
    logic [COUNT_W-1:0] preset_count;

    modport source (output valid, output command, output tone, output beep_number,
                    output preset_count, input ready);
    modport sink (input valid, input command, input tone, input beep_number,
                  input preset_count, output ready);
endinterface

// File: rtl/bcpg_out_if.sv
interface bcpg_out_if;
    import bcpg_pkg::*;

    logic               valid;
    logic               ready;
    logic               pwm_enable;
    logic [PITCH_W-1:0] pwm_period;
    logic [PITCH_W-1:0] pwm_compare;

    modport source (output valid, output pwm_enable, output pwm_period,
                    output pwm_compare, input ready);
    modport sink (input valid, input pwm_enable, input pwm_period,
                  input pwm_compare, output ready);
endinterface

// File: rtl/bcpg_regs.sv
module bcpg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bcpg_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bcpg_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bcpg_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output bcpg_pkg::cfg_t                  cfg
);
    import bcpg_pkg::*;

    logic [TICKS_W-1:0] on_ticks_reg;
    logic [TICKS_W-1:0] off_ticks_reg;
    logic [TICKS_W-1:0] pause_ticks_reg;
    logic               wr_en;
    logic [1:0]         reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel & penable & pwrite;

    // Register writes in the access phase of a transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_ticks_reg    <= ON_TICKS_RESET;
            off_ticks_reg   <= OFF_TICKS_RESET;
            pause_ticks_reg <= PAUSE_TICKS_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_ON_TICKS:    on_ticks_reg    <= pwdata[TICKS_W-1:0];
                REG_OFF_TICKS:   off_ticks_reg   <= pwdata[TICKS_W-1:0];
                REG_PAUSE_TICKS: pause_ticks_reg <= pwdata[TICKS_W-1:0];
                REG_UNUSED:      ;
            endcase
        end
    end

    // Read data, zero extended.
    always_comb
    begin
        unique case (reg_index)
            REG_ON_TICKS:    prdata = {{(APB_DATA_W-TICKS_W){1'b0}}, on_ticks_reg};
            REG_OFF_TICKS:   prdata = {{(APB_DATA_W-TICKS_W){1'b0}}, off_ticks_reg};
            REG_PAUSE_TICKS: prdata = {{(APB_DATA_W-TICKS_W){1'b0}}, pause_ticks_reg};
            REG_UNUSED:      prdata = '0;
        endcase
    end

    assign cfg = '{on_ticks: on_ticks_reg, off_ticks: off_ticks_reg,
                   pause_ticks: pause_ticks_reg};
endmodule

// File: rtl/bcpg_engine.sv
module bcpg_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  bcpg_pkg::cfg_t cfg,
    bcpg_in_if.sink        item,
    bcpg_out_if.source     result
);
    import bcpg_pkg::*;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_ON    = 2'd1;
    localparam logic [1:0] PH_OFF   = 2'd2;
    localparam logic [1:0] PH_PAUSE = 2'd3;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    // Input register.
    logic               in_valid_reg;
    logic [CMD_W-1:0]   cmd_reg;
    logic [TONE_W-1:0]  tone_reg;
    logic [COUNT_W-1:0] number_reg;
    logic [COUNT_W-1:0] preset_reg;

    // Pattern state.
    logic [1:0]           phase_reg,   phase_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [COUNT_W-1:0]   counter_reg, counter_next;
    pitch_t               pitch_reg,   pitch_next;
    logic                 on_reg,      on_next;

    // Result register.
    logic out_valid_reg;

    logic                 advance;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [COUNT_W:0]     counter_inc;
    pitch_t               tone_pair;
    pitch_t               start_pitch;

    assign advance    = in_valid_reg & (~out_valid_reg | result.ready);
    assign item.ready = ~in_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready & item.valid)
        begin
            cmd_reg    <= item.command;
            tone_reg   <= item.tone;
            number_reg <= item.beep_number;
            preset_reg <= item.preset_count;
        end
    end

    // Saturating elapsed count, counter increment and pitch to load on a beep start.
    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg
                                                      : elapsed_reg + 1'b1;
    assign counter_inc = {1'b0, counter_reg} + 1'b1;
    assign tone_pair   = tone_pitch(tone_reg);
    assign start_pitch = (tone_reg == TONE_KEEP) ? pitch_reg : tone_pair;

    // Next pattern state for the item in the input register.
    always_comb
    begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        counter_next = counter_reg;
        pitch_next   = pitch_reg;
        on_next      = on_reg;
        unique case (cmd_reg)
            CMD_TICK:
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        on_next      = 1'b1;
                        pitch_next   = start_pitch;
                        phase_next   = PH_ON;
                        elapsed_next = '0;
                        counter_next = '0;
                    end
                    PH_ON:
                    begin
                        if (elapsed_inc > {1'b0, cfg.on_ticks})
                        begin
                            on_next      = 1'b0;
                            phase_next   = PH_OFF;
                            elapsed_next = '0;
                        end
                        else
                        begin
                            elapsed_next = elapsed_inc;
                        end
                    end
                    PH_OFF:
                    begin
                        if (elapsed_inc > {1'b0, cfg.off_ticks})
                        begin
                            elapsed_next = '0;
                            if (counter_inc < {1'b0, number_reg})
                            begin
                                on_next      = 1'b1;
                                pitch_next   = start_pitch;
                                phase_next   = PH_ON;
                                counter_next = counter_inc[COUNT_W-1:0];
                            end
                            else
                            begin
                                counter_next = '0;
                                phase_next   = PH_PAUSE;
                            end
                        end
                        else
                        begin
                            elapsed_next = elapsed_inc;
                        end
                    end
                    PH_PAUSE:
                    begin
                        if (elapsed_inc > {1'b0, cfg.pause_ticks})
                        begin
                            on_next      = 1'b1;
                            pitch_next   = start_pitch;
                            phase_next   = PH_ON;
                            elapsed_next = '0;
                        end
                        else
                        begin
                            elapsed_next = elapsed_inc;
                        end
                    end
                endcase
            end
            CMD_PRESET:
            begin
                counter_next = preset_reg;
            end
            CMD_CLEAR:
            begin
                phase_next   = PH_IDLE;
                elapsed_next = '0;
                on_next      = 1'b0;
            end
            CMD_NONE:
            begin
            end
        endcase
    end

    // State update and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            elapsed_reg   <= '0;
            counter_reg   <= '0;
            pitch_reg     <= '0;
            on_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg   <= phase_next;
                elapsed_reg <= elapsed_next;
                counter_reg <= counter_next;
                pitch_reg   <= pitch_next;
                on_reg      <= on_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The result of an item is the output state after its update.
    assign result.valid       = out_valid_reg;
    assign result.pwm_enable  = on_reg;
    assign result.pwm_period  = pitch_reg.period;
    assign result.pwm_compare = pitch_reg.compare;
endmodule

// File: rtl/beep_count_pattern_generator.sv
// Beep count pattern generator. Every item is a one-millisecond tick, a preset of the
// beep counter, or a clear, and every item yields exactly one result: the buzzer PWM
// enable and the period/compare pair in force after that item. A tick while idle starts
// a group; each beep then lasts on_ticks+1 ticks, the gaps between beeps off_ticks+1
// ticks, and the pause after a group of beep_number beeps pause_ticks+1 ticks. The
// block takes one item per clock cycle while the receiver takes each result. An accepted
// item is held in the input register, and its result is presented from the result
// register once the next-state step has updated the state. The single next-state step
// between the two registers sets that rate. A result held by the receiver keeps the
// following item waiting in the input register. Registers are written over the APB port
// at byte addresses 0 (on_ticks), 4 (off_ticks) and 8 (pause_ticks); the user must write
// them only while the block is idle, which the block itself does not enforce.
module beep_count_pattern_generator (
    input  logic                            clk,
    input  logic                            rst_n,
    bcpg_in_if.sink                         item,
    bcpg_out_if.source                      result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bcpg_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bcpg_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bcpg_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import bcpg_pkg::*;

    cfg_t cfg;

    // Configuration registers.
    bcpg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Pattern sequencer.
    bcpg_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .result (result)
    );
endmodule
